[design/assert_macros.svh]
// Assertion macros for the RTL of the bloom filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bf_pkg.sv]
// Shared types, constants and helpers for the bloom filter.
`default_nettype none

package bf_pkg;

    localparam int unsigned BF_MAX_BITS     = 65536;
    localparam int          BF_HASH_W       = 64;
    localparam int          BF_ROT_BITS     = 8;
    localparam int          BF_SIZE_W       = 17;
    localparam int          BF_ROUNDS_W     = 3;
    localparam int          BF_WORD_W       = 32;
    localparam int          BF_SEL_W        = 5;
    localparam int          BF_STEP_BITS    = 2;
    localparam int          BF_DIV_STEPS    = BF_HASH_W / BF_STEP_BITS;
    localparam int          BF_STEP_CNT_W   = $clog2(BF_DIV_STEPS);
    localparam int          BF_CFG_INDEX_W  = 8;
    localparam int          BF_CFG_DATA_W   = 17;

    localparam logic [BF_SIZE_W-1:0]   BF_FILTER_BITS_RST = 17'd65536;
    localparam logic [BF_ROUNDS_W-1:0] BF_HASH_ROUNDS_RST = 3'd1;

    // Configuration register indexes
    localparam logic [BF_CFG_INDEX_W-1:0] CFG_FILTER_BITS = 8'd0;
    localparam logic [BF_CFG_INDEX_W-1:0] CFG_HASH_ROUNDS = 8'd1;

    typedef logic [BF_HASH_W-1:0] hash_t;
    typedef logic [BF_SIZE_W-1:0] size_t;

    // Rotate a hash left by the fixed rotation amount.
    function automatic hash_t bf_rotl(input hash_t v);
        bf_rotl = {v[BF_HASH_W-BF_ROT_BITS-1:0], v[BF_HASH_W-1:BF_HASH_W-BF_ROT_BITS]};
    endfunction

    // One restoring remainder step: shift in one bit, subtract size if it fits.
    function automatic size_t bf_mod_step(input size_t rem, input logic b, input size_t size);
        logic [BF_SIZE_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, size})
        begin
            t = t - {1'b0, size};
        end
        bf_mod_step = t[BF_SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/bloom_filter_rotate_mod.sv]
// Bloom filter top level: sequencer, shared remainder unit and bit store.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------
//  in      | in_valid / in_stall  | req_type, key_hash
//  out     | out_valid / out_stall| present
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item is accepted in idle and then worked round by round; a query
// that hits a clear bit ends early. Each round runs the hash through the shared
// remainder unit (two bits of the 64-bit hash a cycle), then a read and a check.
// After reset the block clears the bit store one 32-bit row a cycle, over all
// MAX_BITS/32 rows, with in_stall high; cfg writes are taken always.
// A held result in the output register does not block the next item; the block
// waits at the end of an item only while that register is still full.
`default_nettype none

module bloom_filter_rotate_mod
    import bf_pkg::*;
#(
    parameter int unsigned MAX_BITS = BF_MAX_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      req_type,
    input  wire logic [BF_HASH_W-1:0]      key_hash,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           present,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [BF_CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BF_CFG_DATA_W-1:0]  cfg_data
);

`include "assert_macros.svh"

    localparam int ROWS   = (MAX_BITS + BF_WORD_W - 1) / BF_WORD_W;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = $clog2(MAX_BITS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t                   state_reg,       state_next;
    hash_t                    h_reg,           h_next;
    hash_t                    dsh_reg,         dsh_next;
    size_t                    rem_reg,         rem_next;
    size_t                    size_reg,        size_next;
    logic [BF_STEP_CNT_W-1:0] step_reg,        step_next;
    logic [BF_ROUNDS_W-1:0]   round_reg,       round_next;
    logic [BF_ROUNDS_W-1:0]   rounds_reg,      rounds_next;
    logic                     query_reg,       query_next;
    logic                     hit_reg,         hit_next;
    logic                     out_valid_reg,   out_valid_next;
    logic                     present_reg,     present_next;
    logic [ADDR_W-1:0]        clr_reg,         clr_next;
    size_t                    filter_bits_reg, filter_bits_next;
    logic [BF_ROUNDS_W-1:0]   hash_rounds_reg, hash_rounds_next;

    size_t                    size_eff;
    size_t                    rem_mid;
    size_t                    rem_step;
    logic [IDX_W-1:0]         bit_idx;
    logic [ADDR_W-1:0]        row_addr;
    logic [BF_SEL_W-1:0]      bit_sel;
    logic [BF_WORD_W-1:0]     row_rdata;
    logic [BF_WORD_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]        ram_waddr;
    logic                     ram_we;
    logic                     probe_bit;
    logic                     out_free;
    logic                     last_round;
    logic                     in_round;
    logic                     insert_load;

    // Zero size acts as one; sizes above the store saturate to its length.
    always_comb
    begin
        if (filter_bits_reg == '0)
        begin
            size_eff = size_t'(1);
        end
        else if ({16'd0, filter_bits_reg} > 33'(MAX_BITS))
        begin
            size_eff = size_t'(MAX_BITS);
        end
        else
        begin
            size_eff = filter_bits_reg;
        end
    end

    // Shared remainder unit: two restoring steps a cycle, top bits first.
    assign rem_mid  = bf_mod_step(rem_reg, dsh_reg[BF_HASH_W-1], size_reg);
    assign rem_step = bf_mod_step(rem_mid, dsh_reg[BF_HASH_W-2], size_reg);

    // Split the finished remainder into a row and a bit within the row.
    assign bit_idx   = IDX_W'(rem_reg);
    assign row_addr  = ADDR_W'(bit_idx >> BF_SEL_W);
    assign bit_sel   = bit_idx[BF_SEL_W-1:0];
    assign probe_bit = row_rdata[bit_sel];

    assign out_free   = !out_valid_reg || !out_stall;
    assign last_round = (round_reg + 3'd1) == rounds_reg;

    // Bit store writes: zero rows during the clear pass, set a bit on insert.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = row_addr;
        ram_wdata = row_rdata | (BF_WORD_W'(1) << bit_sel);
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_CHECK && !query_reg)
        begin
            ram_we = 1'b1;
        end
    end

    bf_ram #(
        .WIDTH (BF_WORD_W),
        .DEPTH (ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (row_addr),
        .rdata (row_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        h_next           = h_reg;
        dsh_next         = dsh_reg;
        rem_next         = rem_reg;
        size_next        = size_reg;
        step_next        = step_reg;
        round_next       = round_reg;
        rounds_next      = rounds_reg;
        query_next       = query_reg;
        hit_next         = hit_reg;
        out_valid_next   = out_valid_reg;
        present_next     = present_reg;
        clr_next         = clr_reg;
        filter_bits_next = filter_bits_reg;
        hash_rounds_next = hash_rounds_reg;

        // Drop the result once the consumer takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes; unknown indexes are ignored.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FILTER_BITS: filter_bits_next = cfg_data[BF_SIZE_W-1:0];
                CFG_HASH_ROUNDS: hash_rounds_next = cfg_data[BF_ROUNDS_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    h_next      = bf_rotl(key_hash);
                    dsh_next    = bf_rotl(key_hash);
                    rem_next    = '0;
                    step_next   = '0;
                    round_next  = '0;
                    rounds_next = hash_rounds_reg;
                    size_next   = size_eff;
                    query_next  = req_type;
                    hit_next    = 1'b1;
                    // No rounds: nothing probed, a query answers present.
                    state_next  = (hash_rounds_reg == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_step;
                dsh_next  = dsh_reg << BF_STEP_BITS;
                step_next = step_reg + 1'b1;
                if (step_reg == BF_STEP_CNT_W'(BF_DIV_STEPS - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (query_reg && !probe_bit)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (last_round)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    h_next     = bf_rotl(h_reg);
                    dsh_next   = bf_rotl(h_reg);
                    rem_next   = '0;
                    step_next  = '0;
                    round_next = round_reg + 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    present_next   = query_reg & hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            h_reg           <= '0;
            dsh_reg         <= '0;
            rem_reg         <= '0;
            size_reg        <= size_t'(1);
            step_reg        <= '0;
            round_reg       <= '0;
            rounds_reg      <= '0;
            query_reg       <= 1'b0;
            hit_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            present_reg     <= 1'b0;
            clr_reg         <= '0;
            filter_bits_reg <= BF_FILTER_BITS_RST;
            hash_rounds_reg <= BF_HASH_ROUNDS_RST;
        end
        else
        begin
            state_reg       <= state_next;
            h_reg           <= h_next;
            dsh_reg         <= dsh_next;
            rem_reg         <= rem_next;
            size_reg        <= size_next;
            step_reg        <= step_next;
            round_reg       <= round_next;
            rounds_reg      <= rounds_next;
            query_reg       <= query_next;
            hit_reg         <= hit_next;
            out_valid_reg   <= out_valid_next;
            present_reg     <= present_next;
            clr_reg         <= clr_next;
            filter_bits_reg <= filter_bits_next;
            hash_rounds_reg <= hash_rounds_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign present   = present_reg;
    assign cfg_ready = 1'b1;

    assign in_round    = (state_reg == ST_DIV) || (state_reg == ST_CHECK);
    assign insert_load = (state_reg == ST_DONE) && out_free && !query_reg;

    // The remainder never reaches the size while the unit iterates.
    `ASSERT_SAME(a_rem_below_size, state_reg == ST_DIV, rem_reg < size_reg, "remainder out of range")

    // Rounds are only worked while the count is below the latched round total.
    `ASSERT_SAME(a_round_in_range, in_round, round_reg < rounds_reg, "round count overrun")

    // An insert always reports absent when its result is loaded.
    `ASSERT_NEXT(a_insert_absent, insert_load, out_valid && !present, "insert reported present")

endmodule

`default_nettype wire

[design/bf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2048,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[verif/bloom_filter_rotate_mod_test.sv]
// Self-checking testbench for the rotate-and-modulo bloom filter, with its own shadow bit store.
`default_nettype none

module bloom_filter_rotate_mod_test;
    import bf_pkg::*;

    // Run control. The slowest correct run is about 1650 words at seven rounds
    // plus stall tails, the store clear and one long hold-off, and the cycle limit
    // sits well above that run.
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned HOLD_CYCLES  = 1500;
    localparam int unsigned TAIL_CYCLES  = 260;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned KEY_POOL_MAX = 256;
    localparam int unsigned RAND_PHASES  = 11;
    localparam int unsigned PHASE_WORDS  = 148;
    localparam int unsigned PRESSURE_PHASE = 5;

    // Request kinds on req_type
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Register indexes that decode to nothing
    localparam logic [BF_CFG_INDEX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [BF_CFG_INDEX_W-1:0] CFG_UNUSED_HI = 8'd255;

    typedef struct packed {
        logic  kind;
        hash_t key;
    } probe_word_t;

    typedef struct packed {
        logic  kind;
        hash_t key;
        logic  hit;
    } present_due_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic                      req_type  = REQ_INSERT;
    logic [BF_HASH_W-1:0]      key_hash  = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      present;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [BF_CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BF_CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow copy of the filter: bit store and both registers.
    bit                        shadow_bits [0:BF_MAX_BITS-1];
    logic [BF_SIZE_W-1:0]      shadow_size   = BF_FILTER_BITS_RST;
    logic [BF_ROUNDS_W-1:0]    shadow_rounds = BF_HASH_ROUNDS_RST;

    probe_word_t               req_backlog [$];
    present_due_t              present_due [$];
    hash_t                     key_pool [$];

    int unsigned               send_idle_pct = 0;
    int unsigned               recv_stall_pct = 0;
    logic                      hold_arm = 1'b0;
    int unsigned               hold_left = 0;
    int unsigned               fail_count = 0;
    int unsigned               cycle_count = 0;

    bloom_filter_rotate_mod u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .key_hash  (key_hash),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .present   (present),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Walk the rounds on the shadow store: rotate left by eight, reduce modulo
    // the effective size, then set the bit (insert) or test it (query).
    // A size of zero acts as one; a size past the store saturates to the store.
    // Zero rounds probe nothing, so a query then answers present.
    function automatic logic probe_filter(input logic kind, input hash_t key);
        hash_t       spin;
        hash_t       span;
        int unsigned slot;
        int unsigned rnd;
        logic        all_set;
        spin    = key;
        all_set = 1'b1;
        if (shadow_size == '0)
            span = 1;
        else if (shadow_size > BF_MAX_BITS)
            span = BF_MAX_BITS;
        else
            span = hash_t'(shadow_size);
        for (rnd = 0; rnd < int'(shadow_rounds); rnd++)
        begin
            spin = (spin << BF_ROT_BITS) | (spin >> (BF_HASH_W - BF_ROT_BITS));
            slot = 32'(spin % span);
            if (kind == REQ_QUERY)
            begin
                // stop at the first clear bit
                if (!shadow_bits[slot])
                begin
                    all_set = 1'b0;
                    break;
                end
            end
            else
            begin
                shadow_bits[slot] = 1'b1;
            end
        end
        return (kind == REQ_QUERY) ? all_set : 1'b0;
    endfunction

    function automatic hash_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_word(input logic kind, input hash_t key);
        req_backlog.insert(req_backlog.size(), probe_word_t'{kind: kind, key: key});
    endfunction

    // Report the first few failures in full; count the rest silently.
    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Hold one register write until the port takes it, then track it in the shadow.
    // Leave cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [BF_CFG_INDEX_W-1:0] idx,
                             input logic [BF_CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_FILTER_BITS)
            shadow_size = data[BF_SIZE_W-1:0];
        else if (idx == CFG_HASH_ROUNDS)
            shadow_rounds = data[BF_ROUNDS_W-1:0];
    endtask

    task automatic set_regs(input logic [BF_CFG_DATA_W-1:0] size_data,
                            input logic [BF_CFG_DATA_W-1:0] rounds_data);
        @(posedge clk);
        write_reg(CFG_FILTER_BITS, size_data);
        write_reg(CFG_HASH_ROUNDS, rounds_data);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued word went in and every answer came back.
    // Sample on the falling edge so all rising-edge updates have settled.
    task automatic drain();
        @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || present_due.size() != 0)
            @(negedge clk);
    endtask

    // Sender: present the next backlog word once the current one is taken,
    // idling at random. Predict each word at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_INSERT;
            key_hash <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                present_due.insert(present_due.size(),
                                   present_due_t'{kind: req_type, key: key_hash,
                                                  hit: probe_filter(req_type, key_hash)});
            end
            // hold a stalled word; otherwise advance or go idle
            if (!in_valid || !in_stall)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    req_type <= req_backlog[0].kind;
                    key_hash <= req_backlog[0].key;
                    req_backlog.delete(0);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here once the sequencer arms it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: check each accepted answer against the oldest prediction,
    // then pick the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (present_due.size() == 0)
                begin
                    log_failure($sformatf("unexpected word at cycle %0d: present=%0b",
                                          cycle_count, present));
                end
                else
                begin
                    if (present !== present_due[0].hit)
                        log_failure($sformatf(
                            "present mismatch at cycle %0d, %s key=%h: expected %0b, got %0b",
                            cycle_count, present_due[0].kind == REQ_QUERY ? "query" : "insert",
                            present_due[0].key, present_due[0].hit, present));
                    present_due.delete(0);
                end
            end
            if (hold_left != 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        hash_t                     key;
        int unsigned               phase;
        int unsigned               n;
        int unsigned               pick;
        logic [BF_CFG_DATA_W-1:0]  size_data;
        logic [BF_CFG_DATA_W-1:0]  rounds_data;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: full size, one round. The block clears its store
        // first, so these words wait on in_stall for a while.
        queue_word(REQ_INSERT, '0);
        queue_word(REQ_QUERY, '0);
        queue_word(REQ_QUERY, '1);
        queue_word(REQ_INSERT, '1);
        queue_word(REQ_QUERY, '1);
        queue_word(REQ_QUERY, 64'h0123_4567_89AB_CDEF);
        queue_word(REQ_INSERT, 64'h8000_0000_0000_0001);
        queue_word(REQ_QUERY, 64'h8000_0000_0000_0001);
        drain();

        // Zero size acts as one: every probe lands on bit zero, already set.
        set_regs(17'd0, 17'd7);
        queue_word(REQ_QUERY, rand64());
        queue_word(REQ_INSERT, rand64());
        drain();

        // Oversized size saturates; zero rounds probe nothing and a query hits.
        set_regs(17'h1FFFF, 17'd0);
        key = rand64();
        queue_word(REQ_QUERY, key);
        queue_word(REQ_INSERT, key);
        queue_word(REQ_QUERY, key);
        drain();

        // Writes to unknown indexes must be dropped; then the smallest real size.
        @(posedge clk);
        write_reg(CFG_UNUSED_LO, BF_CFG_DATA_W'($urandom));
        write_reg(CFG_UNUSED_HI, BF_CFG_DATA_W'($urandom));
        write_reg(CFG_FILTER_BITS, 17'd1);
        cfg_valid <= 1'b0;
        queue_word(REQ_QUERY, rand64());
        drain();

        // Full size, seven rounds: a stored key hits, a one-bit neighbor mostly misses.
        set_regs(17'd65536, 17'd7);
        key = rand64();
        queue_word(REQ_INSERT, key);
        queue_word(REQ_QUERY, key);
        queue_word(REQ_QUERY, key ^ 64'd1);
        drain();

        // Shrink the size over the old contents without clearing.
        set_regs(17'd37, 17'd3);
        queue_word(REQ_QUERY, key);
        key = rand64();
        queue_word(REQ_INSERT, key);
        queue_word(REQ_QUERY, key);
        queue_word(REQ_QUERY, rand64());
        drain();

        // Random phases: rotate the idling mix and the settings each time.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (phase == PRESSURE_PHASE)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            case ($urandom_range(0, 9))
                0:       size_data = 17'd0;
                1:       size_data = 17'd1;
                2:       size_data = 17'($urandom_range(2, 8));
                3:       size_data = 17'd65536;
                4:       size_data = 17'(65536 + $urandom_range(1, 65535));
                5:       size_data = 17'd65535;
                6, 7:    size_data = 17'($urandom_range(9, 300));
                default: size_data = 17'($urandom_range(1, 65536));
            endcase
            // mostly real round counts; now and then zero; junk in the unused bits
            rounds_data = {14'($urandom), 3'($urandom_range(1, 7))};
            if ($urandom_range(0, 9) == 0)
                rounds_data[BF_ROUNDS_W-1:0] = '0;
            set_regs(size_data, rounds_data);

            // Inserts feed a pool of keys; most queries reuse a pooled key, and the rest
            // are mutated or fresh keys.
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45 || key_pool.size() == 0)
                begin
                    key = rand64();
                    queue_word(REQ_INSERT, key);
                    key_pool.insert(key_pool.size(), key);
                    if (key_pool.size() > KEY_POOL_MAX)
                        key_pool.delete(0);
                end
                else if (pick < 80)
                begin
                    queue_word(REQ_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
                end
                else if (pick < 90)
                begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    key[$urandom_range(0, BF_HASH_W - 1)] ^= 1'b1;
                    queue_word(REQ_QUERY, key);
                end
                else
                begin
                    queue_word(REQ_QUERY, rand64());
                end
            end

            // Hold the receiver off while the sender keeps pushing, so the
            // output register fills and the block backs up into in_stall.
            if (phase == PRESSURE_PHASE)
            begin
                @(posedge clk);
                hold_arm <= 1'b1;
                @(posedge clk);
                hold_arm <= 1'b0;
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+design
design/bf_pkg.sv
design/bf_ram.sv
design/bloom_filter_rotate_mod.sv
verif/bloom_filter_rotate_mod_test.sv
